// ===== rtl/jes_pkg.sv =====
`default_nettype none

package jes_pkg;

  // Field and register widths
  localparam int CFG_W    = 5;
  localparam int START_W  = 5;
  localparam int STEP_W   = 7;
  localparam int MEMBER_W = 5;
  localparam int PICK_W   = 5;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_SEL_BIT = 2;

  // Register indexes
  localparam logic REG_CIRCLE_SIZE = 1'b0;
  localparam logic REG_PICK_COUNT  = 1'b1;

  // Reset values and limits
  localparam logic [CFG_W-1:0] RESET_CIRCLE_SIZE = 5'd13;
  localparam logic [CFG_W-1:0] RESET_PICK_COUNT  = 5'd5;
  localparam int MAX_RESULTS         = 16;
  localparam int MAX_INTERVAL        = 100;
  localparam int DEFAULT_MAX_MEMBERS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_WALK_STEP,
    ST_WALK_NEXT,
    ST_EMIT
  } jes_state_t;

  typedef struct packed {
    logic load;
    logic walk_start;
    logic walk_step;
    logic walk_commit;
    logic step_dec;
    logic step_reload;
    logic emit;
  } jes_cmd_t;

  typedef struct packed {
    logic step_zero;
    logic walk_done;
    logic final_pick;
    logic bad;
    logic out_free;
  } jes_stat_t;

endpackage

`default_nettype wire

// ===== rtl/jes_ctrl.sv =====
`default_nettype none

module jes_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jes_pkg::jes_stat_t stat,
  output jes_pkg::jes_cmd_t  cmd
);
  import jes_pkg::*;

  jes_state_t state_r;
  jes_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        if (stat.bad || stat.step_zero) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_WALK_STEP;
        end
      end
      ST_WALK_STEP: begin
        if (stat.walk_done) begin
          cmd.walk_commit = 1'b1;
          cmd.step_dec    = 1'b1;
          state_nxt       = ST_ADVANCE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_WALK_NEXT: begin
        if (stat.walk_done) begin
          cmd.walk_commit = 1'b1;
          cmd.step_reload = 1'b1;
          state_nxt       = ST_ADVANCE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.final_pick || stat.bad) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.walk_start = 1'b1;
            state_nxt      = ST_WALK_NEXT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/jes_dp.sv =====
`default_nettype none

module jes_dp #(
  parameter int MAX_MEMBERS = jes_pkg::DEFAULT_MAX_MEMBERS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [jes_pkg::CFG_W-1:0]     circle_size,
  input  logic [jes_pkg::CFG_W-1:0]     pick_count,
  input  logic [jes_pkg::START_W-1:0]   start_position,
  input  logic [jes_pkg::STEP_W-1:0]    step_interval,
  input  jes_pkg::jes_cmd_t             cmd,
  output jes_pkg::jes_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [jes_pkg::MEMBER_W-1:0]  out_member_number,
  output logic                          out_last_pick,
  output logic                          out_bad_request
);
  import jes_pkg::*;

  localparam int IW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int NW = $clog2(MAX_MEMBERS + 1);
  localparam int CW = (NW > CFG_W) ? NW : CFG_W;
  localparam int PW = ((IW + 1) > MEMBER_W) ? (IW + 1) : MEMBER_W;

  logic [CW-1:0]          cs_ext;
  logic [CW-1:0]          pc_ext;
  logic [CW-1:0]          n_eff;
  logic [CW-1:0]          picks_a;
  logic [CW-1:0]          picks_b;
  logic [CW-1:0]          picks_eff;
  logic                   req_bad;
  logic [PW-1:0]          member_full;

  logic [MAX_MEMBERS-1:0] present_r;
  logic [IW-1:0]          nm1_r;
  logic [IW-1:0]          pos_r;
  logic [IW-1:0]          cand_r;
  logic [STEP_W-1:0]      step_m1_r;
  logic [STEP_W-1:0]      stepcnt_r;
  logic [PICK_W-1:0]      rem_r;
  logic                   bad_r;
  logic                   out_valid_r;
  logic [MEMBER_W-1:0]    out_member_r;
  logic                   out_last_r;
  logic                   out_bad_r;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x,
                                             input logic [IW-1:0] last);
    logic [IW-1:0] r;
    if (x == last) begin
      r = '0;
    end else begin
      r = x + IW'(1);
    end
    return r;
  endfunction

  // Clamp the configuration for the request being loaded
  always_comb begin
    cs_ext = CW'(circle_size);
    pc_ext = CW'(pick_count);
    if (cs_ext == '0) begin
      n_eff = CW'(1);
    end else if (cs_ext > CW'(MAX_MEMBERS)) begin
      n_eff = CW'(MAX_MEMBERS);
    end else begin
      n_eff = cs_ext;
    end
    picks_a   = (pc_ext == '0) ? CW'(1) : pc_ext;
    picks_b   = (picks_a > n_eff) ? n_eff : picks_a;
    picks_eff = (picks_b > CW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : picks_b;
    req_bad   = (start_position == '0) || (CW'(start_position) > n_eff) ||
                (step_interval == '0) || (step_interval > STEP_W'(MAX_INTERVAL));
  end

  assign member_full = PW'(pos_r) + PW'(1);

  // Circle contents and walk position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < MAX_MEMBERS; i++) begin
        present_r[i] <= (CW'(i) < n_eff);
      end
      nm1_r     <= IW'(n_eff - CW'(1));
      pos_r     <= IW'(start_position - START_W'(1));
      step_m1_r <= step_interval - STEP_W'(1);
      stepcnt_r <= step_interval - STEP_W'(1);
      rem_r     <= PICK_W'(picks_eff);
      bad_r     <= req_bad;
    end else begin
      if (cmd.emit) begin
        present_r[pos_r] <= 1'b0;
        rem_r            <= rem_r - PICK_W'(1);
      end
      if (cmd.walk_commit) begin
        pos_r <= cand_r;
      end
      if (cmd.step_dec) begin
        stepcnt_r <= stepcnt_r - STEP_W'(1);
      end else if (cmd.step_reload) begin
        stepcnt_r <= step_m1_r;
      end
    end
    if (cmd.walk_start) begin
      cand_r <= wrap_inc(pos_r, nm1_r);
    end else if (cmd.walk_step) begin
      cand_r <= wrap_inc(cand_r, nm1_r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_member_r <= bad_r ? '0 : member_full[MEMBER_W-1:0];
      out_last_r   <= bad_r || (rem_r == PICK_W'(1));
      out_bad_r    <= bad_r;
    end
  end

  assign stat.step_zero  = (stepcnt_r == '0);
  assign stat.walk_done  = present_r[cand_r] || (cand_r == pos_r);
  assign stat.final_pick = (rem_r == PICK_W'(1));
  assign stat.bad        = bad_r;
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_member_number = out_member_r;
  assign out_last_pick     = out_last_r;
  assign out_bad_request   = out_bad_r;

endmodule

`default_nettype wire

// ===== rtl/josephus_elimination_sequence.sv =====
`default_nettype none

// Josephus elimination over a circle of members numbered 1 to circle_size
// (clamped to 1..MAX_MEMBERS). Each input transaction gives a start member
// and a step interval; the block counts interval-1 places among members
// still present, returns that member as one output transaction, removes it
// and carries on from the next member present, returning pick_count members
// (clamped to 1..circle size, at most 16) with last_pick set on the final
// one. A start of 0 or beyond the circle, or an interval of 0 or above 100,
// returns a single transaction with member_number 0, last_pick and
// bad_request set. Requests are served one at a time: in_stall stays high
// from acceptance until the final result has been placed in the output
// register. The controller walks the circle one position per cycle,
// skipping removed members: for each counted place it checks the count
// and then walks to the next member present; when the count is done it
// emits the pick and, for all but the final pick, moves off the removed
// member to the next one present. Output back-pressure holds the sequence
// only while a result waits to be taken. circle_size and pick_count are
// written through the APB port at byte addresses 0 and 4 (reset 13 and 5)
// and must only be changed while no request is in flight.
module josephus_elimination_sequence #(
  parameter int MAX_MEMBERS = jes_pkg::DEFAULT_MAX_MEMBERS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [jes_pkg::START_W-1:0]     in_start_position,
  input  logic [jes_pkg::STEP_W-1:0]      in_step_interval,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [jes_pkg::MEMBER_W-1:0]    out_member_number,
  output logic                            out_last_pick,
  output logic                            out_bad_request,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jes_pkg::PADDR_W-1:0]     paddr,
  input  logic [jes_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [jes_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import jes_pkg::*;

  logic [CFG_W-1:0] circle_size_r;
  logic [CFG_W-1:0] pick_count_r;
  logic             cfg_wr;
  jes_cmd_t         cmd;
  jes_stat_t        stat;

  // Zero-wait-state port: every access completes in its access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register file; low address bits are ignored, unused bits of the write
  // data are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circle_size_r <= RESET_CIRCLE_SIZE;
      pick_count_r  <= RESET_PICK_COUNT;
    end else if (cfg_wr) begin
      case (paddr[REG_SEL_BIT])
        REG_CIRCLE_SIZE: circle_size_r <= pwdata[CFG_W-1:0];
        REG_PICK_COUNT:  pick_count_r  <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the selected register, zero-extended
  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_CIRCLE_SIZE: prdata = APB_DATA_W'(circle_size_r);
      REG_PICK_COUNT:  prdata = APB_DATA_W'(pick_count_r);
      default:         prdata = '0;
    endcase
  end

  // Sequencer: accepts a request, steps the walk, hands results out
  jes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Circle state, counters and the output register
  jes_dp #(
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .circle_size       (circle_size_r),
    .pick_count        (pick_count_r),
    .start_position    (in_start_position),
    .step_interval     (in_step_interval),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_member_number (out_member_number),
    .out_last_pick     (out_last_pick),
    .out_bad_request   (out_bad_request)
  );

endmodule

`default_nettype wire
